@@ rtl/core/spv_pkg.sv @@
// shared types, codes and constants for the sample playback voice
package spv_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS    = 16;
    localparam int POS_INT_BITS   = 13;
    localparam int COUNT_BITS     = 13;
    localparam int STEP_BITS      = 20;
    localparam int STEP_FRAC_BITS = 16;
    localparam int LOAD_IDX_BITS  = 12;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 20;

    // parameter defaults
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int FRAC_BITS_DEF   = 16;

    // register reset values
    localparam logic [STEP_BITS-1:0] STEP_RESET = 20'h10000;

    // item actions
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_START = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SAMPLE_COUNT   = 2'd0,
        CFG_LOOP_ENABLE    = 2'd1,
        CFG_STEP_RATIO     = 2'd2,
        CFG_START_DISABLED = 2'd3
    } cfg_index_t;

    // playback mode
    typedef enum logic [2:0] {
        MODE_DISABLED   = 3'b001,
        MODE_ENABLED    = 3'b010,
        MODE_COMPLETING = 3'b100
    } mode_t;

endpackage

@@ rtl/core/sample_playback_voice.sv @@
// top level of the sample playback voice with linear interpolation
// a tick item's result passes the memory read and stage-one registers, then the output register
// throughput: one item per cycle while the output is not held; a tick whose integer
//   position is at least twice the sample count first stalls while a 13-step
//   restoring remainder reduces the position
// the two-port sample memory read and the interpolation multiply set the pace
// reset: mode enabled, position zero, registers to defaults; memory is not cleared
module sample_playback_voice
    import spv_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [CFG_DATA_BITS-1:0]       cfg_data,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_action,
    input  logic [LOAD_IDX_BITS-1:0]       s_load_index,
    input  logic signed [SAMPLE_BITS-1:0]  s_load_value,
    // result items
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_BITS-1:0]  m_audio_out,
    output logic                           m_ended
);

    localparam int ADDR_W    = $clog2(MAX_SAMPLES);
    localparam int IW        = ((ADDR_W > POS_INT_BITS) ? ADDR_W : POS_INT_BITS) + 1;
    localparam int PW        = POS_INT_BITS + FRAC_BITS;
    localparam int SHL       = (FRAC_BITS >= STEP_FRAC_BITS) ? FRAC_BITS - STEP_FRAC_BITS : 0;
    localparam int SHR       = (FRAC_BITS >= STEP_FRAC_BITS) ? 0 : STEP_FRAC_BITS - FRAC_BITS;
    localparam int SW        = STEP_BITS + SHL;
    localparam int PRODW     = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int RED_STEPS = POS_INT_BITS;
    localparam int RCW       = $clog2(RED_STEPS + 1);

    // configuration registers
    logic [COUNT_BITS-1:0] sample_count_reg;
    logic                  loop_enable_reg;
    logic [STEP_BITS-1:0]  step_ratio_reg;

    // voice state
    logic [PW-1:0] pos_reg, pos_next;
    mode_t         mode_reg, mode_next;

    // position remainder sequencer
    logic                    red_busy_reg, red_busy_next;
    logic [RCW-1:0]          red_cnt_reg, red_cnt_next;
    logic [POS_INT_BITS-1:0] red_rem_reg, red_rem_next;
    logic [POS_INT_BITS-1:0] red_num_reg, red_num_next;

    // interpolation stage
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_ended_reg;
    logic                 s1_bzero_reg;
    logic [FRAC_BITS-1:0] s1_frac_reg;

    // output register
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_audio_reg;
    logic                          m_ended_reg;

    // decode of the current position
    logic [IW-1:0]           cnt_w, max_w, ip_w, idx_w;
    logic [COUNT_BITS-1:0]   n_eff;
    logic [POS_INT_BITS-1:0] ip, ip_wrap, ip_eff;
    logic [FRAC_BITS-1:0]    frac;
    logic [POS_INT_BITS:0]   ip_inc;
    logic                    over, end_case, need_reduce, last, tick_active;
    logic [ADDR_W-1:0]       addr_a, addr_b;
    logic [SW-1:0]           step_wide;
    logic [PW-1:0]           step_scaled, pos_adv;
    logic                    adv, accept, is_load, red_start;
    logic                    mem_wr_en, mem_rd_en;
    logic [POS_INT_BITS:0]   rem_sh;
    logic [POS_INT_BITS-1:0] rem_step;

    // memory read data and interpolation
    logic [SAMPLE_BITS-1:0]        rd_a, rd_b;
    logic signed [SAMPLE_BITS-1:0] samp_a, samp_b;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [PRODW-1:0]       prod, mix_sum, mix;

    // effective sample count and position fields
    assign cnt_w = IW'(sample_count_reg);
    assign max_w = IW'(MAX_SAMPLES);
    assign n_eff = (cnt_w > max_w) ? max_w[COUNT_BITS-1:0] : sample_count_reg;
    assign ip    = pos_reg[PW-1:FRAC_BITS];
    assign frac  = pos_reg[FRAC_BITS-1:0];

    // end and wrap decisions
    assign over        = (ip >= n_eff);
    assign end_case    = over && (!loop_enable_reg || (mode_reg == MODE_COMPLETING));
    assign ip_wrap     = ip - n_eff;
    assign ip_eff      = over ? ip_wrap : ip;
    assign ip_inc      = {1'b0, ip_eff} + {{POS_INT_BITS{1'b0}}, 1'b1};
    assign last        = (ip_inc >= {1'b0, n_eff});
    assign tick_active = (action_t'(s_action) == ACT_TICK) && (n_eff != '0)
                         && (mode_reg != MODE_DISABLED);
    assign need_reduce = tick_active && over && !end_case && (ip_wrap >= n_eff);

    // sample addresses
    assign ip_w   = IW'(ip_eff);
    assign addr_a = ip_w[ADDR_W-1:0];
    assign addr_b = last ? '0 : addr_a + ADDR_W'(1);
    assign idx_w  = IW'(s_load_index);

    // step scaled to the position's fraction width
    assign step_wide   = SW'(step_ratio_reg) << SHL;
    assign step_scaled = PW'(step_wide >> SHR);
    assign pos_adv     = {ip_eff, frac} + step_scaled;

    // handshake
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv && !need_reduce && !red_busy_reg;
    assign accept    = s_valid && s_ready;
    assign is_load   = (action_t'(s_action) == ACT_LOAD);
    assign red_start = s_valid && need_reduce && !red_busy_reg && !cfg_wr_en;
    assign mem_wr_en = accept && is_load && (idx_w < max_w);
    assign mem_rd_en = accept && tick_active && !end_case;

    // one restoring remainder step
    assign rem_sh   = {red_rem_reg, red_num_reg[POS_INT_BITS-1]};
    assign rem_step = (rem_sh >= {1'b0, n_eff}) ? POS_INT_BITS'(rem_sh - {1'b0, n_eff})
                                                : rem_sh[POS_INT_BITS-1:0];

    // next voice state
    always_comb begin
        pos_next      = pos_reg;
        mode_next     = mode_reg;
        red_busy_next = red_busy_reg;
        red_cnt_next  = red_cnt_reg;
        red_rem_next  = red_rem_reg;
        red_num_next  = red_num_reg;
        s1_valid_next = s1_valid_reg;

        if (red_busy_reg) begin
            red_rem_next = rem_step;
            red_num_next = red_num_reg << 1;
            red_cnt_next = red_cnt_reg - RCW'(1);
            if (red_cnt_reg == RCW'(1)) begin
                red_busy_next = 1'b0;
                pos_next      = {rem_step, frac};
            end
        end else if (red_start) begin
            red_busy_next = 1'b1;
            red_cnt_next  = RCW'(RED_STEPS);
            red_rem_next  = '0;
            red_num_next  = ip;
        end

        if (adv) begin
            s1_valid_next = accept && tick_active;
        end

        if (accept) begin
            unique case (action_t'(s_action))
                ACT_TICK: begin
                    if (tick_active) begin
                        if (end_case) begin
                            mode_next = MODE_DISABLED;
                            pos_next  = '0;
                        end else begin
                            pos_next = pos_adv;
                        end
                    end
                end
                ACT_LOAD: begin
                end
                ACT_START: begin
                    pos_next  = '0;
                    mode_next = MODE_ENABLED;
                end
                ACT_STOP: begin
                    if (mode_reg == MODE_ENABLED) begin
                        mode_next = MODE_COMPLETING;
                    end
                end
                default: begin
                end
            endcase
        end

        // a register write restarts any remainder in flight
        if (cfg_wr_en) begin
            red_busy_next = 1'b0;
            if ((cfg_index_t'(cfg_index) == CFG_START_DISABLED) && cfg_data[0]) begin
                mode_next = MODE_DISABLED;
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
            loop_enable_reg  <= 1'b0;
            step_ratio_reg   <= STEP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SAMPLE_COUNT:   sample_count_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_LOOP_ENABLE:    loop_enable_reg  <= cfg_data[0];
                CFG_STEP_RATIO:     step_ratio_reg   <= cfg_data[STEP_BITS-1:0];
                CFG_START_DISABLED: begin
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            mode_reg     <= MODE_ENABLED;
            red_busy_reg <= 1'b0;
            red_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            mode_reg     <= mode_next;
            red_busy_reg <= red_busy_next;
            red_cnt_reg  <= red_cnt_next;
            s1_valid_reg <= s1_valid_next;
            if (adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // remainder datapath
    always_ff @(posedge aclk) begin
        red_rem_reg <= red_rem_next;
        red_num_reg <= red_num_next;
    end

    // stage one payload, captured with the memory read
    always_ff @(posedge aclk) begin
        if (accept && tick_active) begin
            s1_ended_reg <= end_case;
            s1_bzero_reg <= last && !loop_enable_reg;
            s1_frac_reg  <= frac;
        end
    end

    // sample memory
    spv_sample_ram #(
        .DEPTH  (MAX_SAMPLES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (mem_wr_en),
        .wr_addr   (idx_w[ADDR_W-1:0]),
        .wr_data   (s_load_value),
        .rd_en     (mem_rd_en),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // linear interpolation: a + (b - a) * f, floored
    assign samp_a  = $signed(rd_a);
    assign samp_b  = s1_bzero_reg ? '0 : $signed(rd_b);
    assign diff    = $signed({samp_b[SAMPLE_BITS-1], samp_b})
                     - $signed({samp_a[SAMPLE_BITS-1], samp_a});
    assign frac_s  = $signed({1'b0, s1_frac_reg});
    assign prod    = PRODW'(diff) * PRODW'(frac_s);
    assign mix_sum = (PRODW'(samp_a) <<< FRAC_BITS) + prod;
    assign mix     = mix_sum >>> FRAC_BITS;

    // output register
    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg) begin
            m_audio_reg <= s1_ended_reg ? '0 : mix[SAMPLE_BITS-1:0];
            m_ended_reg <= s1_ended_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_audio_out = m_audio_reg;
    assign m_ended     = m_ended_reg;

endmodule

@@ rtl/core/spv_sample_ram.sv @@
// sample storage: one write port, two registered read ports
module spv_sample_ram
    import spv_pkg::*;
#(
    parameter int DEPTH  = MAX_SAMPLES_DEF,
    parameter int ADDR_W = $clog2(MAX_SAMPLES_DEF)
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  logic [SAMPLE_BITS-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [ADDR_W-1:0]      rd_addr_a,
    input  logic [ADDR_W-1:0]      rd_addr_b,
    output logic [SAMPLE_BITS-1:0] rd_data_a,
    output logic [SAMPLE_BITS-1:0] rd_data_b
);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read ports, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

@@ verif/sample_playback_voice_tb.sv @@
// testbench for the sample playback voice: interpolation predictor, handshake drivers, checks
`timescale 1ns / 1ps

module sample_playback_voice_tb;
    import spv_pkg::*;

    localparam int     POS_BITS      = POS_INT_BITS + FRAC_BITS_DEF;
    localparam longint FRAC_ONE      = longint'(1) << FRAC_BITS_DEF;
    localparam int     ITEM_TARGET   = 850;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     IDLE_LIMIT    = 3000;
    localparam int     HOLD_CYCLES   = 400;

    // what the next tick does with the current state
    typedef enum {
        TICK_SILENT,
        TICK_END,
        TICK_PLAY
    } tick_kind_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] audio;
        logic                          ended;
    } voice_sample_t;

    // voice state mirror and the queue of samples still owed by the block
    class voice_scoreboard;
        logic signed [SAMPLE_BITS-1:0] sample_mem [MAX_SAMPLES_DEF];
        bit                            loaded [MAX_SAMPLES_DEF];
        logic [POS_BITS-1:0]           position;
        mode_t                         mode;
        logic [COUNT_BITS-1:0]         count_reg;
        logic                          loop_reg;
        logic [STEP_BITS-1:0]          step_reg;
        logic                          start_dis_reg;
        voice_sample_t                 pending [$];
        int                            items_seen;
        int                            checked;
        int                            ends_seen;
        int                            wraps_seen;
        int                            long_wraps;
        int                            errors;

        function new();
            position      = '0;
            mode          = MODE_ENABLED;
            count_reg     = '0;
            loop_reg      = 1'b0;
            step_reg      = STEP_RESET;
            start_dis_reg = 1'b0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_SAMPLE_COUNT: count_reg = data[COUNT_BITS-1:0];
                CFG_LOOP_ENABLE:  loop_reg  = data[0];
                CFG_STEP_RATIO:   step_reg  = data[STEP_BITS-1:0];
                default: begin
                    start_dis_reg = data[0];
                    if (data[0])
                        mode = MODE_DISABLED;
                end
            endcase
        endfunction

        // counts above the memory size behave as a full memory
        function int unsigned active_count();
            return (count_reg > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : count_reg;
        endfunction

        // entries read by the next tick; ib < 0 means the padding zero
        function tick_kind_t plan_tick(output int unsigned ia, output int ib);
            int unsigned n;
            int unsigned ip;
            n  = active_count();
            ia = 0;
            ib = -1;
            if (n == 0 || mode == MODE_DISABLED)
                return TICK_SILENT;
            ip = position[POS_BITS-1:FRAC_BITS_DEF];
            if (ip >= n) begin
                if (!loop_reg || mode == MODE_COMPLETING)
                    return TICK_END;
                ip = ip % n;
            end
            ia = ip;
            if (ip + 1 < n)
                ib = ip + 1;
            else if (loop_reg)
                ib = 0;
            return TICK_PLAY;
        endfunction

        // first entry the next tick would read before it was ever loaded
        function bit unloaded_slot(output int unsigned slot);
            int unsigned ia;
            int          ib;
            slot = 0;
            if (plan_tick(ia, ib) != TICK_PLAY)
                return 0;
            if (!loaded[ia]) begin
                slot = ia;
                return 1;
            end
            if (ib >= 0 && !loaded[ib]) begin
                slot = ib;
                return 1;
            end
            return 0;
        endfunction

        // update the mirror for an accepted item and queue its sample, if any
        function void note_item(action_t act, logic [LOAD_IDX_BITS-1:0] idx,
                                logic [SAMPLE_BITS-1:0] val);
            int unsigned             ia;
            int unsigned             raw_ip;
            int                      ib;
            tick_kind_t              kind;
            logic [FRAC_BITS_DEF-1:0] frac;
            longint                  a;
            longint                  b;
            longint                  mix;
            longint                  next_pos;
            voice_sample_t           s;
            items_seen++;
            case (act)
                ACT_LOAD: begin
                    sample_mem[idx] = val;
                    loaded[idx]     = 1'b1;
                end
                ACT_START: begin
                    position = '0;
                    mode     = MODE_ENABLED;
                end
                ACT_STOP: begin
                    if (mode == MODE_ENABLED)
                        mode = MODE_COMPLETING;
                end
                default: begin
                    raw_ip = position[POS_BITS-1:FRAC_BITS_DEF];
                    kind   = plan_tick(ia, ib);
                    if (kind == TICK_END) begin
                        mode     = MODE_DISABLED;
                        position = '0;
                        s.audio  = '0;
                        s.ended  = 1'b1;
                        pending.insert(pending.size(), s);
                        ends_seen++;
                    end else if (kind == TICK_PLAY) begin
                        if (raw_ip >= active_count())
                            wraps_seen++;
                        if (raw_ip >= 2 * active_count())
                            long_wraps++;
                        // floor of the weighted mix, always between the two entries
                        frac     = position[FRAC_BITS_DEF-1:0];
                        a        = longint'(sample_mem[ia]);
                        b        = (ib < 0) ? 0 : longint'(sample_mem[ib]);
                        mix      = a * (FRAC_ONE - longint'(frac)) + b * longint'(frac);
                        s.audio  = SAMPLE_BITS'(mix >>> FRAC_BITS_DEF);
                        s.ended  = 1'b0;
                        pending.insert(pending.size(), s);
                        next_pos = (longint'(ia) << FRAC_BITS_DEF) + longint'(frac)
                                   + longint'(step_reg);
                        position = POS_BITS'(next_pos);
                    end
                end
            endcase
        endfunction

        function void check_result(logic signed [SAMPLE_BITS-1:0] audio, logic ended);
            voice_sample_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected sample: audio_out %0d ended %0b", $time, audio, ended);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (audio !== want.audio) begin
                $display("%0t: audio_out mismatch: expected %0d, actual %0d",
                         $time, want.audio, audio);
                errors++;
            end
            if (ended !== want.ended) begin
                $display("%0t: ended mismatch: expected %0b, actual %0b",
                         $time, want.ended, ended);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk         = 1'b0;
    logic                          aresetn      = 1'b0;
    logic                          cfg_wr_en    = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data     = '0;
    logic                          s_valid      = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_action     = '0;
    logic [LOAD_IDX_BITS-1:0]      s_load_index = '0;
    logic signed [SAMPLE_BITS-1:0] s_load_value = '0;
    logic                          m_valid;
    logic                          m_ready      = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_audio_out;
    logic                          m_ended;

    voice_scoreboard sb = new();
    int              burst_left   = 0;
    bit              hold_request = 1'b0;

    sample_playback_voice u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_load_index (s_load_index),
        .s_load_value (s_load_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_audio_out  (m_audio_out),
        .m_ended      (m_ended)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // offer one item, in bursts with random gaps between them
    task automatic send_item(action_t act, logic [LOAD_IDX_BITS-1:0] idx,
                             logic [SAMPLE_BITS-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_action     <= act;
        s_load_index <= idx;
        s_load_value <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(act, idx, val);
    endtask

    // tick, loading first any entry it would read that was never written
    task automatic send_tick();
        int unsigned slot;
        while (sb.unloaded_slot(slot))
            send_item(ACT_LOAD, LOAD_IDX_BITS'(slot), SAMPLE_BITS'($urandom));
        send_item(ACT_TICK, LOAD_IDX_BITS'($urandom), SAMPLE_BITS'($urandom));
    endtask

    task automatic send_ctl(action_t act);
        send_item(act, LOAD_IDX_BITS'($urandom), SAMPLE_BITS'($urandom));
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering, collect every owed sample, let silent ticks drain
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: changing stall patterns plus one long hold-off
    initial begin : result_sink
        int hold_left;
        int mode_left;
        int pattern;
        int cyc;
        bit hold_done;
        hold_left = 0;
        mode_left = 0;
        pattern   = 0;
        cyc       = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                pattern   = $urandom_range(0, 3);
                mode_left = $urandom_range(30, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (pattern)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((cyc % 5) != 0);
                endcase
            end
        end
    end

    // compare each accepted sample
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_audio_out, m_ended);
    end

    // watchdog on cycles with no item moving on either side
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned          count;
        int                   pick;
        int                   len;
        logic [STEP_BITS-1:0] step;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty sample: ticks give nothing, stop and start only touch the mode
        send_tick();
        send_ctl(ACT_STOP);
        send_tick();
        send_ctl(ACT_START);

        // full-scale values at the first entries and at the last address
        send_item(ACT_LOAD, 12'd0, 16'h8000);
        send_item(ACT_LOAD, 12'd1, 16'h7FFF);
        send_item(ACT_LOAD, 12'd2, 16'h0000);
        send_item(ACT_LOAD, 12'd3, 16'hFFFF);
        send_item(ACT_LOAD, 12'hFFF, 16'hAAAA);
        settle();

        // one-shot at half speed: runs to the end marker, then stays silent
        write_reg(CFG_SAMPLE_COUNT, 20'd4);
        write_reg(CFG_STEP_RATIO, 20'h08000);
        repeat (10) send_tick();
        send_ctl(ACT_STOP);
        send_ctl(ACT_START);
        settle();

        // looping at 1.5x from a disabled voice; stop finishes the current pass
        write_reg(CFG_LOOP_ENABLE, 20'd1);
        write_reg(CFG_STEP_RATIO, 20'h18000);
        write_reg(CFG_START_DISABLED, 20'd1);
        send_tick();
        send_ctl(ACT_START);
        repeat (4) send_tick();
        send_ctl(ACT_STOP);
        repeat (3) send_tick();
        settle();

        // clearing start_disabled keeps the voice off until a start
        write_reg(CFG_START_DISABLED, 20'd0);
        send_tick();
        send_ctl(ACT_START);
        settle();

        // count past the memory size, slowest then fastest step
        write_reg(CFG_SAMPLE_COUNT, 20'd8191);
        write_reg(CFG_STEP_RATIO, 20'd1);
        repeat (2) send_tick();
        settle();
        write_reg(CFG_STEP_RATIO, 20'hFFFFF);
        repeat (3) send_tick();
        settle();

        // steady looping while the result side holds off
        write_reg(CFG_SAMPLE_COUNT, 20'd16);
        write_reg(CFG_STEP_RATIO, STEP_RESET);
        send_ctl(ACT_START);
        hold_request = 1'b1;
        repeat (150) send_tick();

        // random phases: new settings, then mostly ticks with some control
        while (sb.items_seen < ITEM_TARGET) begin
            settle();
            pick = $urandom_range(0, 99);
            if (pick < 5)
                count = 0;
            else if (pick < 15)
                count = 1;
            else if (pick < 20)
                count = MAX_SAMPLES_DEF;
            else if (pick < 25)
                count = $urandom_range(MAX_SAMPLES_DEF + 1, 8191);
            else if (pick < 40)
                count = $urandom_range(25, 300);
            else
                count = $urandom_range(2, 24);
            write_reg(CFG_SAMPLE_COUNT, CFG_DATA_BITS'(count));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_LOOP_ENABLE, CFG_DATA_BITS'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) != 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    step = 20'd1;
                else if (pick < 20)
                    step = 20'hFFFFF;
                else if (pick < 45)
                    step = STEP_RESET;
                else if (pick < 75)
                    step = STEP_BITS'($urandom_range(1, 20'h3FFFF));
                else
                    step = STEP_BITS'($urandom_range(1, 20'hFFFFF));
                write_reg(CFG_STEP_RATIO, step);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                write_reg(CFG_START_DISABLED, 20'd1);
            else if (pick < 25)
                write_reg(CFG_START_DISABLED, 20'd0);

            if ($urandom_range(0, 9) < 6)
                send_ctl(ACT_START);
            len = $urandom_range(8, 50);
            repeat (len) begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    send_tick();
                else if (pick < 85)
                    send_item(ACT_LOAD, LOAD_IDX_BITS'($urandom), SAMPLE_BITS'($urandom));
                else if (pick < 93)
                    send_ctl(ACT_START);
                else
                    send_ctl(ACT_STOP);
            end
        end
        settle();

        $display("covered %0d items, %0d samples checked, %0d end markers",
                 sb.items_seen, sb.checked, sb.ends_seen);
        $display("loop wraps %0d, of which %0d from twice the count or more",
                 sb.wraps_seen, sb.long_wraps);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
